### rtl/bdps_pkg.sv
// ---------------------------------------------------------------------------
// bdps_pkg: shared types and constants of the burst duty pattern sequencer
// Holds the packed pattern layout, the register indexes and the structs that
// travel between the length units, the tick engine and the top level.
// ---------------------------------------------------------------------------
package bdps_pkg;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_PATTERN_COUNT = 3'd0;
   localparam logic [2:0] CSR_PATTERN_BASE  = 3'd1;

   // Number of pattern slots that the 2-bit pattern index can address.
   localparam int PATTERN_SLOTS = 4;

   // Field widths.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 55;
   localparam int COUNT_W     = 3;
   localparam int INDEX_W     = 2;
   localparam int REPEATS_W   = 16;
   localparam int INTERVAL_W  = 32;
   localparam int DUTY_W      = 7;
   localparam int REM_W       = 7;

   // Bit positions of the packed pattern word.
   localparam int REPEATS_LSB  = 0;
   localparam int INTERVAL_LSB = 16;
   localparam int DUTY_LSB     = 48;

   // Percent scale and the highest duty that is honored.
   localparam logic [DUTY_W-1:0] PCT_SCALE = 7'd100;
   localparam logic [DUTY_W-1:0] DUTY_MAX  = 7'd99;

   // Reciprocal of 100 for a 32-bit dividend: x/100 = (x*RECIP_100) >> 37,
   // exact for every 32-bit x. The quotient fits 26 bits.
   localparam int                 RECIP_W      = 31;
   localparam int                 RECIP_PROD_W = INTERVAL_W + RECIP_W;
   localparam int                 RECIP_SHIFT  = 37;
   localparam int                 QUOT_W       = 26;
   localparam logic [RECIP_W-1:0] RECIP_100    = 31'h51EB851F;

   // Reciprocal of 100 for the small product remainder*duty (at most 9801):
   // y/100 = (y*FRAC_RECIP_100) >> 20, exact for every y below 43690.
   localparam int                FRAC_W         = 14;
   localparam int                FRAC_PROD_W    = 2 * FRAC_W;
   localparam int                FRAC_SHIFT     = 20;
   localparam logic [FRAC_W-1:0] FRAC_RECIP_100 = 14'd10486;

   // Precomputed view of one pattern, read live by the tick engine.
   typedef struct packed {
      logic [REPEATS_W-1:0]  repeats;
      logic [INTERVAL_W-1:0] on_len;
      logic [INTERVAL_W-1:0] off_len;
   } pat_len_type;

   // One result word.
   typedef struct packed {
      logic               level;
      logic               on_event;
      logic               off_event;
      logic               cycle_end;
      logic               pattern_end;
      logic               sequence_end;
      logic [INDEX_W-1:0] active_pattern;
      logic [REPEATS_W-1:0] cycles_done;
   } rsp_type;

endpackage

### rtl/bdps_len_unit.sv
// ---------------------------------------------------------------------------
// bdps_len_unit: phase length unit of one pattern slot
// Captures a pattern write and works out the on and off phase lengths: the
// interval is split into hundreds and a remainder with a reciprocal
// multiplication, and both parts are scaled by the duty.
// ---------------------------------------------------------------------------
module bdps_len_unit
   import bdps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output pat_len_type           pat_len,
   output logic                  busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUOT,
      ST_SPLIT,
      ST_FRAC,
      ST_SCALE,
      ST_FINISH
   } len_state_type;

   len_state_type           state_ff;
   logic [INTERVAL_W-1:0]   interval_ff;
   logic [DUTY_W-1:0]       duty_ff;
   logic [REPEATS_W-1:0]    repeats_ff;
   logic [QUOT_W-1:0]       quot_ff;
   logic [REM_W-1:0]        rem_ff;
   logic [INTERVAL_W-1:0]   whole_ff;
   logic [FRAC_W-1:0]       frac_ff;
   logic [REM_W-1:0]        frac_quot_ff;
   logic                    frac_nz_ff;
   logic [INTERVAL_W-1:0]   on_len_ff;
   logic [INTERVAL_W-1:0]   off_len_ff;

   logic [DUTY_W-1:0]       duty_raw;
   logic [DUTY_W-1:0]       duty_in;
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [QUOT_W-1:0]       quot_in;
   logic [INTERVAL_W-1:0]   hundreds;
   logic [REM_W-1:0]        rem_in;
   logic [INTERVAL_W-1:0]   whole_in;
   logic [FRAC_W-1:0]       frac_in;
   logic [FRAC_PROD_W-1:0]  frac_prod;
   logic [REM_W-1:0]        frac_quot_in;
   logic [FRAC_W-1:0]       frac_back;
   logic                    frac_nz_in;
   logic [INTERVAL_W-1:0]   on_len_in;
   logic [INTERVAL_W-1:0]   off_len_in;

   always_comb begin
      duty_raw = wr_data[DUTY_LSB +: DUTY_W];
      duty_in  = (duty_raw > DUTY_MAX) ? DUTY_MAX : duty_raw;

      // interval = 100*quot + rem
      recip_prod = RECIP_PROD_W'(interval_ff) * RECIP_PROD_W'(RECIP_100);
      quot_in    = recip_prod[RECIP_PROD_W-1:RECIP_SHIFT];
      hundreds   = INTERVAL_W'(quot_ff) * INTERVAL_W'(PCT_SCALE);
      rem_in     = REM_W'(interval_ff - hundreds);

      // interval*duty/100 = quot*duty + (rem*duty)/100
      whole_in     = INTERVAL_W'(quot_ff) * INTERVAL_W'(duty_ff);
      frac_in      = FRAC_W'(rem_ff) * FRAC_W'(duty_ff);
      frac_prod    = FRAC_PROD_W'(frac_ff) * FRAC_PROD_W'(FRAC_RECIP_100);
      frac_quot_in = frac_prod[FRAC_SHIFT +: REM_W];
      frac_back    = FRAC_W'(frac_quot_in) * FRAC_W'(PCT_SCALE);
      frac_nz_in   = (frac_back != frac_ff);

      // off = interval - ceil(interval*duty/100)
      on_len_in  = whole_ff + INTERVAL_W'(frac_quot_ff);
      off_len_in = interval_ff - on_len_in - INTERVAL_W'(frac_nz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         repeats_ff  <= '0;
         on_len_ff   <= '0;
         off_len_ff  <= '0;
      end else if (wr_en) begin
         // A new write restarts the unit even if a computation is running.
         state_ff    <= ST_QUOT;
         repeats_ff  <= wr_data[REPEATS_LSB +: REPEATS_W];
         interval_ff <= wr_data[INTERVAL_LSB +: INTERVAL_W];
         duty_ff     <= duty_in;
      end else begin
         case (state_ff)
            ST_QUOT: begin
               quot_ff  <= quot_in;
               state_ff <= ST_SPLIT;
            end
            ST_SPLIT: begin
               rem_ff   <= rem_in;
               whole_ff <= whole_in;
               state_ff <= ST_FRAC;
            end
            ST_FRAC: begin
               frac_ff  <= frac_in;
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               frac_quot_ff <= frac_quot_in;
               frac_nz_ff   <= frac_nz_in;
               state_ff     <= ST_FINISH;
            end
            ST_FINISH: begin
               on_len_ff  <= on_len_in;
               off_len_ff <= off_len_in;
               state_ff   <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign pat_len.repeats = repeats_ff;
   assign pat_len.on_len  = on_len_ff;
   assign pat_len.off_len = off_len_ff;

endmodule

### rtl/bdps_tick_engine.sv
// ---------------------------------------------------------------------------
// bdps_tick_engine: per-tick state update of the sequencer
// Advances pattern index, cycle count, phase and elapsed ticks for each
// accepted word with run high and registers the event flags of that tick.
// ---------------------------------------------------------------------------
module bdps_tick_engine
   import bdps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic               run,
   input  logic [COUNT_W-1:0] eff_count,
   input  pat_len_type        pat_tab [PATTERN_SLOTS],
   output rsp_type            rsp
);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ON   = 2'd1,
      PH_OFF  = 2'd2
   } phase_type;

   phase_type              phase_ff,    phase_in;
   logic [INDEX_W-1:0]     index_ff,    index_in;
   logic [REPEATS_W-1:0]   counter_ff,  counter_in;
   logic [INTERVAL_W-1:0]  elapsed_ff,  elapsed_in;
   logic                   on_ev_ff,    on_ev_in;
   logic                   off_ev_ff,   off_ev_in;
   logic                   cyc_ev_ff,   cyc_ev_in;
   logic                   pat_ev_ff,   pat_ev_in;
   logic                   seq_ev_ff,   seq_ev_in;

   pat_len_type            cur;
   logic [INTERVAL_W:0]    next_elapsed;

   always_comb begin
      cur          = pat_tab[index_ff];
      next_elapsed = {1'b0, elapsed_ff} + 1'b1;

      phase_in   = phase_ff;
      index_in   = index_ff;
      counter_in = counter_ff;
      elapsed_in = elapsed_ff;
      on_ev_in   = 1'b0;
      off_ev_in  = 1'b0;
      cyc_ev_in  = 1'b0;
      pat_ev_in  = 1'b0;
      seq_ev_in  = 1'b0;

      if (run) begin
         case (phase_ff)
            PH_ON: begin
               if (next_elapsed >= {1'b0, cur.on_len}) begin
                  off_ev_in  = 1'b1;
                  phase_in   = PH_OFF;
                  elapsed_in = '0;
               end else begin
                  elapsed_in = next_elapsed[INTERVAL_W-1:0];
               end
            end
            PH_OFF: begin
               if (next_elapsed >= {1'b0, cur.off_len}) begin
                  cyc_ev_in  = 1'b1;
                  counter_in = counter_ff + 1'b1;
                  phase_in   = PH_IDLE;
                  elapsed_in = '0;
               end else begin
                  elapsed_in = next_elapsed[INTERVAL_W-1:0];
               end
            end
            default: begin
               phase_in   = PH_IDLE;
               elapsed_in = '0;
               if (counter_ff >= cur.repeats) begin
                  pat_ev_in  = 1'b1;
                  counter_in = '0;
                  if (({1'b0, index_ff} + 1'b1) >= eff_count) begin
                     index_in  = '0;
                     seq_ev_in = 1'b1;
                  end else begin
                     index_in = index_ff + 1'b1;
                  end
               end else begin
                  on_ev_in = 1'b1;
                  phase_in = PH_ON;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         index_ff   <= '0;
         counter_ff <= '0;
         elapsed_ff <= '0;
         on_ev_ff   <= 1'b0;
         off_ev_ff  <= 1'b0;
         cyc_ev_ff  <= 1'b0;
         pat_ev_ff  <= 1'b0;
         seq_ev_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         counter_ff <= counter_in;
         elapsed_ff <= elapsed_in;
         on_ev_ff   <= on_ev_in;
         off_ev_ff  <= off_ev_in;
         cyc_ev_ff  <= cyc_ev_in;
         pat_ev_ff  <= pat_ev_in;
         seq_ev_ff  <= seq_ev_in;
      end
   end

   assign rsp.level          = (phase_ff == PH_ON);
   assign rsp.on_event       = on_ev_ff;
   assign rsp.off_event      = off_ev_ff;
   assign rsp.cycle_end      = cyc_ev_ff;
   assign rsp.pattern_end    = pat_ev_ff;
   assign rsp.sequence_end   = seq_ev_ff;
   assign rsp.active_pattern = index_ff;
   assign rsp.cycles_done    = counter_ff;

   // A held tick leaves the sequencer state untouched and raises no event.
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      (step_en && !run) |=> ($stable(phase_ff) && $stable(index_ff) &&
         $stable(counter_ff) && $stable(elapsed_ff) &&
         !on_ev_ff && !off_ev_ff && !cyc_ev_ff && !pat_ev_ff && !seq_ev_ff))
      else $error("held tick changed sequencer state");

   // A pattern end always clears the cycle count and leaves the phase idle.
   a_pattern_end_clears: assert property (@(posedge clock) disable iff (reset)
      pat_ev_ff |-> (counter_ff == '0 && phase_ff == PH_IDLE))
      else $error("pattern end without cleared count");

   // A sequence wrap is a pattern end that lands on pattern zero.
   a_sequence_wrap: assert property (@(posedge clock) disable iff (reset)
      seq_ev_ff |-> (pat_ev_ff && index_ff == '0))
      else $error("sequence end without wrap to pattern zero");

   // At most one of the on, off, cycle-end and pattern-end events fires per tick.
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      $onehot0({on_ev_ff, off_ev_ff, cyc_ev_ff, pat_ev_ff}))
      else $error("more than one tick event raised");

endmodule

### rtl/burst_duty_pattern_sequencer_core.sv
// ---------------------------------------------------------------------------
// burst_duty_pattern_sequencer_core: burst PWM pattern sequencer
// Plays a configured list of duty-cycle patterns, one tick per request word.
// ---------------------------------------------------------------------------
// Each request word is one tick: with req_run high the sequencer advances by
// one tick, with it low the state holds and a word with no events is still
// returned. Every request word gives exactly one response word, which shows
// the level and position after that tick. The block takes one word per clock
// while req_stall is low; the response register is refilled in the same cycle
// in which its word is taken, so words stream back to back as long as the
// response side does not stall. The on and off lengths of each
// pattern, interval*duty/100 and interval*(100-duty)/100 with duty limited
// to 99, are worked out when the pattern register is written: a per-slot
// unit splits the interval into hundreds and a remainder with a reciprocal
// multiplication and scales both parts by the duty, so a pattern write stalls
// the request side in the cycle of the write and while the unit is busy. A
// write to the pattern count register stalls requests only in its own cycle
// and takes effect at once. A pattern count of zero acts as one, and a count
// above MAX_PATTERNS acts as MAX_PATTERNS. Writes to register indexes beyond
// the last pattern are ignored.
// ---------------------------------------------------------------------------
module burst_duty_pattern_sequencer_core
   import bdps_pkg::*;
#(
   parameter int MAX_PATTERNS = 4
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_run,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_level,
   output logic                  rsp_on_event,
   output logic                  rsp_off_event,
   output logic                  rsp_cycle_end,
   output logic                  rsp_pattern_end,
   output logic                  rsp_sequence_end,
   output logic [INDEX_W-1:0]    rsp_active_pattern,
   output logic [REPEATS_W-1:0]  rsp_cycles_done
);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PATTERNS);

   logic [COUNT_W-1:0]       pattern_count_ff;
   logic [COUNT_W-1:0]       eff_count;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     req_accept;
   logic [PATTERN_SLOTS-1:0] lane_busy;
   pat_len_type              pat_tab [PATTERN_SLOTS];
   rsp_type                  rsp;

   // Pattern count register. Its reset value is one pattern.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_count_ff <= COUNT_W'(1);
      end else if (csr_we && csr_addr == CSR_PATTERN_COUNT) begin
         pattern_count_ff <= csr_wdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      if (pattern_count_ff == '0) begin
         eff_count = COUNT_W'(1);
      end else if (pattern_count_ff > MAX_COUNT) begin
         eff_count = MAX_COUNT;
      end else begin
         eff_count = pattern_count_ff;
      end
   end

   // One length unit per implemented pattern slot; unused slots read as an
   // empty pattern and are never reached by the pattern index.
   for (genvar gi = 0; gi < PATTERN_SLOTS; gi++) begin : g_slot
      if (gi < MAX_PATTERNS) begin : g_lane
         localparam logic [CSR_ADDR_W-1:0] LANE_ADDR =
            CSR_ADDR_W'(int'(CSR_PATTERN_BASE) + gi);

         bdps_len_unit u_len_unit (
            .clock   (clock),
            .reset   (reset),
            .wr_en   (csr_we && csr_addr == LANE_ADDR),
            .wr_data (csr_wdata),
            .pat_len (pat_tab[gi]),
            .busy    (lane_busy[gi])
         );
      end else begin : g_unused
         assign pat_tab[gi]   = '0;
         assign lane_busy[gi] = 1'b0;
      end
   end

   // Requests wait while a length unit is busy, while a configuration write
   // is under way, and while the response register holds a word that is not
   // being taken.
   assign req_stall  = (|lane_busy) || csr_we || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   bdps_tick_engine u_tick_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (req_accept),
      .run       (req_run),
      .eff_count (eff_count),
      .pat_tab   (pat_tab),
      .rsp       (rsp)
   );

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_level          = rsp.level;
   assign rsp_on_event       = rsp.on_event;
   assign rsp_off_event      = rsp.off_event;
   assign rsp_cycle_end      = rsp.cycle_end;
   assign rsp_pattern_end    = rsp.pattern_end;
   assign rsp_sequence_end   = rsp.sequence_end;
   assign rsp_active_pattern = rsp.active_pattern;
   assign rsp_cycles_done    = rsp.cycles_done;

   // A response word only appears for a request word accepted just before.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept))
      else $error("response word without accepted request");

   // No tick is taken while a pattern's lengths are still being computed.
   a_no_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (|lane_busy) |-> !req_accept)
      else $error("tick accepted while lengths were being computed");

endmodule
